/* hdl/lams_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lams_pkg: shared constants
// default sizes, phase codes and the area width of the per-process record
// ----------------------------------------------------------------------------
package lams_pkg;
    localparam int MAX_PROCS_DEF  = 16;
    localparam int VALUE_BITS_DEF = 32;
    localparam int AREA_BITS      = 8;

    localparam logic [1:0] PH_LOAD = 2'd0;
    localparam logic [1:0] PH_SORT = 2'd1;
    localparam logic [1:0] PH_EMIT = 2'd2;
endpackage
`default_nettype wire

/* hdl/lams_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lams_mem: process state memory
// one write port, one registered read port; entry holds L, R, marks, area
// ----------------------------------------------------------------------------
module lams_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 74
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* hdl/line_array_marked_sort_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// line_array_marked_sort_core: marked neighbor-exchange sort of a line
// loads up to MAX_PROCS values, runs n-1 rounds, streams n results
// ----------------------------------------------------------------------------
// Words load one per cycle. The word with tlast, or the MAX_PROCS-th word,
// closes the run. Process state lives in one memory, which holds the
// left/right value, the marks and the area of each process. Setup walks the
// n processes. Each of the n-1 rounds sweeps the line through the memory:
// one process is read, modified and written back per cycle, and the boundary
// is carried in registers. Emission reads one process and then loads the
// output register; the next read waits until that load is done, and waits
// while the receiver holds off a full output register. Input is held off from
// the closing word until the last result is in the output register.
module line_array_marked_sort_core #(
    parameter int MAX_PROCS  = lams_pkg::MAX_PROCS_DEF,
    parameter int VALUE_BITS = lams_pkg::VALUE_BITS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // value[31:0]
    input  wire         s_tlast,   // last
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // sorted_value[31:0]
    output logic        m_tlast    // last_res
);
    import lams_pkg::*;

    localparam int AW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int VB = VALUE_BITS;
    localparam int EW = 2 * VB + 2 + AREA_BITS;

    // entry: {area, rmark, lmark, r, l}; values held biased (sign flipped)
    function automatic logic [VB-1:0] bias_in(input logic [31:0] raw);
        logic [VB-1:0] v;
        v = VB'({{32{raw[31]}}, raw});
        v[VB-1] = ~v[VB-1];
        return v;
    endfunction

    logic [1:0]    phase_reg;
    logic [CW-1:0] cnt_reg;      // loaded count n
    logic [CW-1:0] rnd_reg;      // rounds done
    logic [CW-1:0] pos_reg;      // sweep position
    logic          busy_reg;     // read issued last cycle
    logic [AW-1:0] busy_addr_reg;
    logic          setup_reg;

    // boundary carry of the sweep
    logic [VB-1:0] sent_reg;     // right value of i at round start
    logic          rm_reg;       // right mark of i (pending)
    logic [VB-1:0] pl_reg;       // left value of i (pending write)
    logic [AREA_BITS-1:0] pa_reg;
    logic          plm_reg;
    logic          pend_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;

    lams_mem #(.DEPTH(MAX_PROCS), .WIDTH(EW)) u_mem (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [VB-1:0] rl, rr;
    logic          rlm, rrm;
    logic [AREA_BITS-1:0] ra;
    assign rl  = rdata[VB-1:0];
    assign rr  = rdata[2*VB-1:VB];
    assign rlm = rdata[2*VB];
    assign rrm = rdata[2*VB+1];
    assign ra  = rdata[EW-1:2*VB+2];

    // output register
    logic          ov_reg;
    logic [31:0]   od_reg;
    logic          ol_reg;
    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tlast  = ol_reg;

    assign s_tready = (phase_reg == PH_LOAD);
    wire s_acc = s_tvalid && s_tready;
    wire closes = s_tlast || (cnt_reg == CW'(MAX_PROCS - 1));

    logic [CW-1:0] last_idx;
    assign last_idx = cnt_reg - CW'(1);

    // crossing logic at boundary busy_addr-1 | busy_addr
    logic [VB-1:0] x_l;          // new left of i+1
    logic [VB-1:0] back;
    logic          n_lm, n_rm;   // left mark of i+1, right mark of i
    logic [AREA_BITS-1:0] n_a;
    // local ordering of process i
    logic [VB-1:0] o_l, o_r;
    logic          o_lm, o_rm;
    always_comb begin
        x_l = rl; back = sent_reg; n_lm = rlm; n_rm = rm_reg; n_a = ra;
        if (sent_reg > rl) begin
            back = rl; x_l = sent_reg;
            if (rlm && rm_reg) begin
            end else if (rlm) begin
                n_lm = 1'b0; n_a = ra + AREA_BITS'(1); n_rm = 1'b1;
            end else if (rm_reg) begin
                n_lm = 1'b1; n_a = ra - AREA_BITS'(1); n_rm = 1'b0;
            end
        end
        o_l = pl_reg; o_r = back; o_lm = plm_reg; o_rm = n_rm;
        if (pl_reg > back) begin
            o_l = back; o_r = pl_reg; o_lm = n_rm; o_rm = plm_reg;
        end
    end

    logic emit_go;
    assign emit_go = (phase_reg == PH_EMIT) && (!ov_reg || m_tready)
                     && (pos_reg < cnt_reg) && !busy_reg;

    always_comb begin
        we = 1'b0; waddr = AW'(0); wdata = '0;
        raddr = pos_reg[AW-1:0];
        if (s_acc) begin
            we = 1'b1; waddr = cnt_reg[AW-1:0];
            wdata = {AREA_BITS'(0), 2'b00, {VB{1'b0}}, bias_in(s_tdata)};
        end else if (phase_reg == PH_SORT && busy_reg) begin
            we = 1'b1;
            if (setup_reg) begin
                waddr = busy_addr_reg;
                if (busy_addr_reg == AW'(0))
                    wdata = {{AREA_BITS{1'b1}}, 2'b10, rl, {1'b0, {(VB-1){1'b0}}}};
                else if (CW'(busy_addr_reg) == last_idx)
                    wdata = {AREA_BITS'(0), 2'b01, {1'b1, {(VB-1){1'b1}}}, rl};
                else
                    wdata = {AREA_BITS'(0), 2'b00, rl, rl};
            end else if (busy_addr_reg == AW'(0)) begin
                we = 1'b0;
            end else begin
                // write back process i = addr-1 after ordering
                waddr = busy_addr_reg - AW'(1);
                wdata = {pa_reg, o_rm, o_lm, o_r, o_l};
            end
        end else if (phase_reg == PH_SORT && pend_reg) begin
            // last process of the line: no right neighbor, no ordering
            we = 1'b1; waddr = last_idx[AW-1:0];
            wdata = {pa_reg, rm_reg, plm_reg, sent_reg, pl_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LOAD; cnt_reg <= '0; rnd_reg <= '0; pos_reg <= '0;
            busy_reg <= 1'b0; setup_reg <= 1'b0; pend_reg <= 1'b0; ov_reg <= 1'b0;
        end else begin
            if (phase_reg == PH_EMIT && busy_reg) ov_reg <= 1'b1;
            else if (m_tready) ov_reg <= 1'b0;
            unique case (phase_reg)
                PH_LOAD: if (s_acc) begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (closes) begin
                        phase_reg <= PH_SORT; setup_reg <= 1'b1;
                        pos_reg <= '0; rnd_reg <= '0;
                    end
                end
                PH_SORT: begin
                    busy_reg <= (pos_reg < cnt_reg) && !pend_reg;
                    pend_reg <= busy_reg && !setup_reg && (CW'(busy_addr_reg) == last_idx);
                    if (busy_reg && !setup_reg) begin
                        // carry boundary to next process
                        sent_reg <= rr; rm_reg <= rrm;
                        pl_reg <= (busy_addr_reg == AW'(0)) ? rl : x_l;
                        plm_reg <= (busy_addr_reg == AW'(0)) ? rlm : n_lm;
                        pa_reg <= (busy_addr_reg == AW'(0)) ? ra : n_a;
                    end
                    if (pos_reg < cnt_reg && !pend_reg) begin
                        busy_addr_reg <= pos_reg[AW-1:0];
                        pos_reg <= pos_reg + CW'(1);
                    end else if (!busy_reg && !pend_reg) begin
                        pos_reg <= '0;
                        setup_reg <= 1'b0;
                        if (!setup_reg) rnd_reg <= rnd_reg + CW'(1);
                        if ((setup_reg ? CW'(0) : rnd_reg + CW'(1)) >= last_idx)
                            phase_reg <= PH_EMIT;
                    end
                end
                PH_EMIT: begin
                    busy_reg <= emit_go;
                    if (emit_go) begin
                        busy_addr_reg <= pos_reg[AW-1:0];
                        pos_reg <= pos_reg + CW'(1);
                    end
                    if (busy_reg) begin
                        od_reg <= 32'($signed({~(ra[AREA_BITS-1] ? rr[VB-1] : rl[VB-1]),
                                   ra[AREA_BITS-1] ? rr[VB-2:0] : rl[VB-2:0]}));
                        ol_reg <= (CW'(busy_addr_reg) == last_idx);
                        if (CW'(busy_addr_reg) == last_idx) begin
                            phase_reg <= PH_LOAD; cnt_reg <= '0; pos_reg <= '0;
                        end
                    end
                end
                default: phase_reg <= PH_LOAD;
            endcase
        end
    end

    // no input taken outside loading
    a_no_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_LOAD) |-> !s_tready) else $error("input taken while busy");
    // emitted count never passes the loaded count
    a_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_EMIT) |-> (pos_reg <= cnt_reg)) else $error("emit overrun");
    // a last result ends the run
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && phase_reg == PH_EMIT && CW'(busy_addr_reg) == last_idx)
        |=> (phase_reg == PH_LOAD)) else $error("run did not close");
endmodule
`default_nettype wire
